// ----- src/oce_pkg.sv -----
// Shared types and constants for the ordinal category encoder.
package oce_pkg;

	localparam int FeaturesDef = 8;
	localparam int DepthDef    = 64;

	localparam logic [63:0] SignBit  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] QnanBits = 64'h7FF8_0000_0000_0000;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_ENCODE = 2'd2,
		MODE_DECODE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_UNK_REPL = 3'd1,
		ST_UNK_ERR  = 3'd2,
		ST_BAD_CODE = 3'd3,
		ST_BAD_FEAT = 3'd4,
		ST_FULL     = 3'd5,
		ST_NAN      = 3'd6,
		ST_UNK_PASS = 3'd7
	} status_t;

	localparam logic [1:0] REG_NUM_FEATURES   = 2'd0;
	localparam logic [1:0] REG_UNKNOWN_ENABLE = 2'd1;
	localparam logic [1:0] REG_UNKNOWN_CODE   = 2'd2;

	function automatic logic is_nan(input logic [63:0] b);
		return b[62:0] > 63'h7FF0_0000_0000_0000;
	endfunction

	// Unsigned key in numeric order, -0 folded onto +0.
	function automatic logic [63:0] order_key(input logic [63:0] b);
		logic [63:0] v;
		v = (b == SignBit) ? 64'd0 : b;
		return v[63] ? ~v : (v ^ SignBit);
	endfunction

endpackage

// ----- src/oce_table.sv -----
// Key storage: one synchronous RAM with a registered read.
module oce_table import oce_pkg::*; #(
	parameter int AW = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);

	logic [63:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- src/ordinal_category_encoder_core.sv -----
// Ordinal category encoder: per-feature sorted key tables with binary-search lookup.
// One transaction at a time. Clear, a bad feature and a NaN insert touch no table entry.
// Decode does one RAM read of the entry at the given code. Encode runs a binary search,
// a read and a compare per step, then the final compare read. An insert that adds a key
// runs the same search, then shifts the entries from the insert point upward up by one
// slot, each as a read then a write, and writes the new key into the freed slot.
// The result sits in its own output register, so the next transaction is accepted meanwhile.
// A finished transaction waits only while the previous result is still unread.
module ordinal_category_encoder_core import oce_pkg::*; #(
	parameter int FEATURES = FeaturesDef,
	parameter int DEPTH    = DepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode[1:0], feature[4:2], key_bits[68:5], code_in[84:69], zero pad
	input  logic [87:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], code_out[18:3], value_bits[82:19], category_count[89:83], pad
	output logic [95:0] m_tdata
);

	localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int DW = $clog2(DEPTH);
	localparam int CW = DW + 1;
	localparam int AW = FW + DW;

	typedef enum logic [2:0] {
		S_IDLE, S_SRCH, S_SWAIT, S_CHK, S_SHRD, S_SHWR, S_DONE
	} state_t;

	state_t state_q;
	logic [3:0]  nf_q;
	logic        uen_q;
	logic [15:0] ucode_q;
	logic [CW-1:0] cnt_q [FEATURES];

	logic [1:0]  mode_q;
	logic [FW-1:0] feat_q;
	logic [63:0] key_q, okey_q;
	logic [15:0] code_q;
	logic [CW-1:0] lo_q, hi_q, mid_q, n_q;
	logic [CW-1:0] idx_q;

	logic        outv_q;
	logic [2:0]  st_q;
	logic [15:0] cout_q;
	logic [63:0] val_q;
	logic [6:0]  ocnt_q;
	logic [95:0] res_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]   wdata, rdata;

	oce_table #(.AW(AW)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [1:0]  in_mode;
	logic [2:0]  in_feat;
	logic [63:0] in_key;
	logic [15:0] in_code;
	assign in_mode = s_tdata[1:0];
	assign in_feat = s_tdata[4:2];
	assign in_key  = s_tdata[68:5];
	assign in_code = s_tdata[84:69];

	logic [6:0] limit;
	assign limit = (32'(nf_q) < FEATURES) ? 7'(nf_q) : 7'(FEATURES);

	logic [AW-1:0] base;
	assign base = {feat_q, {DW{1'b0}}};

	logic [CW-1:0] mid_n, probe;
	assign mid_n = lo_q + ((hi_q - lo_q) >> 1);
	assign probe = (lo_q < hi_q) ? mid_n : lo_q;

	always_comb begin
		we    = 1'b0;
		waddr = base | AW'(idx_q);
		wdata = rdata;
		raddr = base | AW'(mid_q);
		if (state_q == S_SRCH)
			raddr = base | AW'(probe);
		if (state_q == S_SHRD)
			raddr = base | AW'(idx_q - CW'(1));
		if (state_q == S_SHWR) begin
			we = 1'b1;
			if (idx_q == lo_q)
				wdata = key_q;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = outv_q;
	assign m_tdata  = res_q;

	logic found;
	assign found = (lo_q < n_q) && (order_key(rdata) == okey_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nf_q    <= 4'd1;
			uen_q   <= 1'b0;
			ucode_q <= 16'hFFFF;
			outv_q  <= 1'b0;
			res_q   <= '0;
			for (int i = 0; i < FEATURES; i++)
				cnt_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_FEATURES:   nf_q    <= cfg_data[3:0];
					REG_UNKNOWN_ENABLE: uen_q   <= cfg_data[0];
					REG_UNKNOWN_CODE:   ucode_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_DONE && (!outv_q || m_tready))
				outv_q <= 1'b1;
			else if (m_tready)
				outv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						mode_q <= in_mode;
						feat_q <= FW'(in_feat);
						key_q  <= in_key;
						okey_q <= order_key(in_key);
						code_q <= in_code;
						cout_q <= '0;
						val_q  <= '0;
						lo_q   <= '0;
						if (in_mode == MODE_CLEAR) begin
							for (int i = 0; i < FEATURES; i++)
								cnt_q[i] <= '0;
							st_q    <= ST_OK;
							ocnt_q  <= '0;
							state_q <= S_DONE;
						end else if (7'(in_feat) >= limit) begin
							st_q    <= ST_BAD_FEAT;
							ocnt_q  <= '0;
							state_q <= S_DONE;
						end else begin
							n_q    <= cnt_q[FW'(in_feat)];
							ocnt_q <= 7'(cnt_q[FW'(in_feat)]);
							if (in_mode == MODE_DECODE) begin
								st_q    <= ST_OK;
								mid_q   <= in_code[CW-1:0];
								hi_q    <= '0;
								state_q <= S_SWAIT;
							end else if (is_nan(in_key) && in_mode == MODE_INSERT) begin
								st_q    <= ST_NAN;
								hi_q    <= '0;
								state_q <= S_DONE;
							end else begin
								st_q    <= ST_OK;
								// a NaN key never matches, so its search is skipped
								hi_q    <= is_nan(in_key) ? '0 : cnt_q[FW'(in_feat)];
								state_q <= S_SRCH;
							end
						end
					end
				end
				S_SRCH: begin
					// issue a read at mid, or at lo for the final compare
					mid_q   <= probe;
					state_q <= S_SWAIT;
				end
				S_SWAIT: begin
					if (lo_q < hi_q) begin
						if (order_key(rdata) < okey_q)
							lo_q <= mid_q + CW'(1);
						else
							hi_q <= mid_q;
						state_q <= S_SRCH;
					end else
						state_q <= S_CHK;
				end
				S_CHK: begin
					if (mode_q == MODE_DECODE) begin
						state_q <= S_DONE;
						if (uen_q && code_q == ucode_q) begin
							st_q  <= ST_UNK_PASS;
							val_q <= QnanBits;
						end else if (code_q[15] || {1'b0, code_q} >= 17'(n_q))
							st_q <= ST_BAD_CODE;
						else
							val_q <= rdata;
					end else if (mode_q == MODE_ENCODE) begin
						state_q <= S_DONE;
						if (found)
							cout_q <= 16'(lo_q);
						else if (uen_q) begin
							st_q   <= ST_UNK_REPL;
							cout_q <= ucode_q;
						end else
							st_q <= ST_UNK_ERR;
					end else if (found) begin
						cout_q  <= 16'(lo_q);
						state_q <= S_DONE;
					end else if (32'(n_q) >= DEPTH) begin
						st_q    <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						cout_q  <= 16'(lo_q);
						idx_q   <= n_q;
						cnt_q[feat_q] <= n_q + CW'(1);
						ocnt_q  <= 7'(n_q + CW'(1));
						state_q <= (n_q == lo_q) ? S_SHWR : S_SHRD;
					end
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					if (idx_q == lo_q)
						state_q <= S_DONE;
					else begin
						idx_q <= idx_q - CW'(1);
						state_q <= (idx_q - CW'(1) == lo_q) ? S_SHWR : S_SHRD;
					end
				end
				S_DONE: begin
					if (!outv_q || m_tready) begin
						res_q   <= {6'd0, ocnt_q, val_q, cout_q, st_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !s_tready)
		else $error("accept while busy");
	a_write_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == S_SHWR && mode_q == MODE_INSERT)
		else $error("table write outside insert");

endmodule
